// ===== design/mtng_pkg.sv =====
// Shared constants, types and coefficient tables for the noise generator.
package mtng_pkg;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_NOISE_TYPE = 1'd0;
  localparam logic [0:0] REG_SEED_VALUE = 1'd1;

  // Noise material codes
  localparam logic [1:0] TYPE_PINK   = 2'd0;
  localparam logic [1:0] TYPE_WHITE  = 2'd1;
  localparam logic [1:0] TYPE_BROWN  = 2'd2;
  localparam logic [1:0] TYPE_VELVET = 2'd3;

  localparam logic [31:0] SEED_RESET = 32'd48879;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_INC    = 32'd1013904223;

  // Q2.30 coefficients
  localparam logic signed [31:0] C_PINK_W     = 32'sd575740366;
  localparam logic signed [31:0] C_PINK_OUT   = 32'sd118111601;
  localparam logic signed [31:0] C_POLE6      = 32'sd124474595;
  localparam logic signed [31:0] C_WHITE      = 32'sd279172874;
  localparam logic signed [31:0] C_BROWN_DCY  = 32'sd1071594340;
  localparam logic signed [31:0] C_BROWN_GAIN = 32'sd21474836;

  // Velvet impulse, Q4.28
  localparam logic signed [31:0] VELVET_AMP = 32'sd161061274;

  localparam int CELL_LENGTH = 16;
  localparam int OFS_W       = $clog2(CELL_LENGTH);
  localparam int POS_W       = $clog2(CELL_LENGTH + 1);
  typedef logic [OFS_W-1:0] ofs_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam int NUM_POLES = 7;
  typedef logic [2:0] pole_idx_t;
  localparam pole_idx_t LAST_LEAKY_POLE = 3'd5;
  localparam pole_idx_t LAST_POLE       = 3'd6;

  // Datapath widths of the shared multiply-accumulate unit
  localparam int MA_W   = 33;
  localparam int MB_W   = 32;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 64;

  // Rounding offset used before the final shift of the pink sum
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(64'd1 << 29);

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_HALF
  } base_sel_t;

  typedef enum logic [1:0] {
    TERM_ROUND,
    TERM_RAW,
    TERM_RAW16,
    TERM_ADDEND
  } term_sel_t;

  typedef struct packed {
    logic      mul_en;
    logic      acc_en;
    base_sel_t base_sel;
    term_sel_t term_sel;
  } mac_ctrl_t;

  function automatic logic signed [31:0] pole_decay(input pole_idx_t idx);
    logic signed [31:0] c;
    unique case (idx)
      3'd0:    c = 32'sd1072517758;
      3'd1:    c = 32'sd1066569229;
      3'd2:    c = 32'sd1040455827;
      3'd3:    c = 32'sd930397290;
      3'd4:    c = 32'sd590558003;
      3'd5:    c = -32'sd817761773;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] pole_gain(input pole_idx_t idx);
    logic signed [31:0] c;
    unique case (idx)
      3'd0:    c = 32'sd59611891;
      3'd1:    c = 32'sd80612134;
      3'd2:    c = 32'sd165197327;
      3'd3:    c = 32'sd333381374;
      3'd4:    c = 32'sd572253067;
      3'd5:    c = -32'sd18144089;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== design/mtng_mac.sv =====
// Shared multiplier with registered product and a rounding accumulator.
module mtng_mac (
  input  logic                                   clk,
  input  mtng_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [mtng_pkg::MA_W-1:0]       mul_a,
  input  logic signed [mtng_pkg::MB_W-1:0]       mul_b,
  input  logic signed [mtng_pkg::ACC_W-1:0]      addend,
  output logic signed [mtng_pkg::PROD_W-1:0]     prod,
  output logic signed [mtng_pkg::ACC_W-1:0]      acc,
  output logic signed [mtng_pkg::ACC_W-1:0]      sum
);

  logic [mtng_pkg::ACC_W-1:0] base;
  logic [mtng_pkg::ACC_W-1:0] term;
  logic                       cin;

  always_comb begin
    unique case (ctrl.base_sel)
      mtng_pkg::BASE_ACC:  base = acc;
      mtng_pkg::BASE_HALF: base = mtng_pkg::ACC_HALF;
      default:             base = '0;
    endcase
    cin = 1'b0;
    unique case (ctrl.term_sel)
      mtng_pkg::TERM_ROUND: begin
        // round half up: floor(p / 2^30) plus bit 29
        term = {{(mtng_pkg::ACC_W - mtng_pkg::PROD_W + 30){prod[mtng_pkg::PROD_W-1]}},
                prod[mtng_pkg::PROD_W-1:30]};
        cin  = prod[29];
      end
      mtng_pkg::TERM_RAW:   term = prod[mtng_pkg::ACC_W-1:0];
      mtng_pkg::TERM_RAW16: term = {prod[mtng_pkg::ACC_W-17:0], 16'd0};
      default:              term = addend;
    endcase
    sum = base + term + {{(mtng_pkg::ACC_W-1){1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.acc_en) begin
      acc <= sum;
    end
  end

endmodule

// ===== design/multi_type_noise_generator.sv =====
// Top level of the multi-type noise generator: sequencer, state and ports.
//
//  channel   signals                          direction  content
//  config    cfg_write cfg_index cfg_data     in         noise_type (0), seed_value (1)
//  request   item_valid item_stall restart    in         one request per sample
//  result    result_valid result_stall sample out        Q4.20 sample, saturated
//
// Pink requests take longest from acceptance to a loaded result and velvet
// ones are quickest when no new cell is drawn; any time the previous sample
// is still held in the output register adds to this. The single shared
// 33x32 multiplier sets the request time: every LCG step, pole update and
// the output scaling pass through it one product per cycle.
// rst is synchronous: the generator reloads the default seed and all filter
// state clears. item_stall is high while a request is in progress; a done
// result waits in the output register, and the next request may already run
// from the cycle after the result loads.

module multi_type_noise_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               restart,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [23:0] sample
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LCG_MUL,
    S_LCG_ADD,
    S_P_G,
    S_P_WB,
    S_P_SUM0,
    S_P_SUMP,
    S_P_SL,
    S_P_SH,
    S_P_SHC,
    S_P_P6,
    S_B_G,
    S_B_WB,
    S_W_MUL,
    S_W_ACC,
    S_V_MUL,
    S_V_DRAW,
    S_V_EMIT,
    S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [1:0]  noise_type;
  logic [31:0] seed_value;

  // generator and filter state
  logic [31:0]          lcg_state;
  logic signed [31:0]   pole [mtng_pkg::NUM_POLES];
  logic signed [31:0]   brown_level;
  mtng_pkg::pos_t       velvet_position;
  mtng_pkg::ofs_t       velvet_offset;
  logic                 velvet_positive;
  mtng_pkg::pole_idx_t  idx;

  // shared unit
  mtng_pkg::mac_ctrl_t                      ctrl;
  logic signed [mtng_pkg::MA_W-1:0]         mul_a;
  logic signed [mtng_pkg::MB_W-1:0]         mul_b;
  logic signed [mtng_pkg::ACC_W-1:0]        addend;
  logic signed [mtng_pkg::PROD_W-1:0]       prod;
  logic signed [mtng_pkg::ACC_W-1:0]        acc;
  logic signed [mtng_pkg::ACC_W-1:0]        sum;

  logic signed [31:0]   white;
  logic signed [31:0]   pole_rd;
  mtng_pkg::pole_idx_t  rd_addr;
  logic                 accept;
  logic                 out_free;
  logic                 velvet_hit;
  logic signed [33:0]   v34;
  logic signed [34:0]   v_rnd;
  logic signed [26:0]   v_shr;
  logic signed [23:0]   sample_next;

  mtng_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .addend (addend),
    .prod   (prod),
    .acc    (acc),
    .sum    (sum)
  );

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // w = (s >> 3) - 2^28, done by flipping the top bit of s[31:3]
  assign white      = {{4{~lcg_state[31]}}, lcg_state[30:3]};
  assign pole_rd    = pole[rd_addr];
  assign velvet_hit = (velvet_position == mtng_pkg::pos_t'(velvet_offset));

  always_comb begin
    ctrl     = '{mul_en: 1'b0, acc_en: 1'b0,
                 base_sel: mtng_pkg::BASE_ZERO, term_sel: mtng_pkg::TERM_ROUND};
    mul_a    = '0;
    mul_b    = '0;
    addend   = '0;
    rd_addr  = idx;
    unique case (state)
      S_LCG_MUL: begin
        ctrl.mul_en = 1'b1;
        mul_a       = {1'b0, lcg_state};
        mul_b       = mtng_pkg::LCG_MUL;
      end
      S_LCG_ADD: begin
        // start the first decay product while the LCG settles
        rd_addr     = '0;
        ctrl.mul_en = 1'b1;
        if (noise_type == mtng_pkg::TYPE_BROWN) begin
          mul_a = mtng_pkg::MA_W'(brown_level);
          mul_b = mtng_pkg::C_BROWN_DCY;
        end else begin
          mul_a = mtng_pkg::MA_W'(pole_rd);
          mul_b = mtng_pkg::pole_decay(rd_addr);
        end
      end
      S_P_G, S_B_G: begin
        ctrl.acc_en = 1'b1;
        ctrl.mul_en = 1'b1;
        mul_a       = mtng_pkg::MA_W'(white);
        mul_b       = (state == S_B_G) ? mtng_pkg::C_BROWN_GAIN : mtng_pkg::pole_gain(idx);
      end
      S_P_WB: begin
        ctrl.base_sel = mtng_pkg::BASE_ACC;
        ctrl.mul_en   = 1'b1;
        rd_addr       = 3'(idx + 3'd1);
        if (idx == mtng_pkg::LAST_LEAKY_POLE) begin
          mul_a = mtng_pkg::MA_W'(white);
          mul_b = mtng_pkg::C_PINK_W;
        end else begin
          mul_a = mtng_pkg::MA_W'(pole_rd);
          mul_b = mtng_pkg::pole_decay(rd_addr);
        end
      end
      S_B_WB: begin
        ctrl.base_sel = mtng_pkg::BASE_ACC;
      end
      S_P_SUM0, S_W_ACC: begin
        ctrl.acc_en = 1'b1;
      end
      S_P_SUMP: begin
        ctrl.acc_en   = 1'b1;
        ctrl.base_sel = mtng_pkg::BASE_ACC;
        ctrl.term_sel = mtng_pkg::TERM_ADDEND;
        addend        = mtng_pkg::ACC_W'(pole_rd);
      end
      S_P_SL: begin
        // low 16 bits of the pink sum, unsigned
        ctrl.mul_en = 1'b1;
        mul_a       = {{(mtng_pkg::MA_W-16){1'b0}}, acc[15:0]};
        mul_b       = mtng_pkg::C_PINK_OUT;
      end
      S_P_SH: begin
        ctrl.mul_en   = 1'b1;
        mul_a         = acc[mtng_pkg::MA_W+15:16];
        mul_b         = mtng_pkg::C_PINK_OUT;
        ctrl.acc_en   = 1'b1;
        ctrl.base_sel = mtng_pkg::BASE_HALF;
        ctrl.term_sel = mtng_pkg::TERM_RAW;
      end
      S_P_SHC: begin
        ctrl.acc_en   = 1'b1;
        ctrl.base_sel = mtng_pkg::BASE_ACC;
        ctrl.term_sel = mtng_pkg::TERM_RAW16;
        ctrl.mul_en   = 1'b1;
        mul_a         = mtng_pkg::MA_W'(white);
        mul_b         = mtng_pkg::C_POLE6;
      end
      S_P_P6: begin
        // pole 6 from the rounded product; accumulator keeps the pink result
      end
      S_W_MUL: begin
        ctrl.mul_en = 1'b1;
        mul_a       = mtng_pkg::MA_W'(white);
        mul_b       = mtng_pkg::C_WHITE;
      end
      S_V_MUL: begin
        // offset = (s * CELL_LENGTH) >> 32
        ctrl.mul_en = 1'b1;
        mul_a       = {1'b0, lcg_state};
        mul_b       = mtng_pkg::MB_W'(mtng_pkg::CELL_LENGTH);
      end
      S_V_EMIT: begin
        ctrl.acc_en   = 1'b1;
        ctrl.term_sel = mtng_pkg::TERM_ADDEND;
        if (velvet_hit) begin
          addend = velvet_positive ? mtng_pkg::ACC_W'(mtng_pkg::VELVET_AMP)
                                   : -mtng_pkg::ACC_W'(mtng_pkg::VELVET_AMP);
        end
      end
      default: begin
      end
    endcase
  end

  // output rounding: floor((v + 128) / 256), saturated to 24 bits
  always_comb begin
    unique case (noise_type)
      mtng_pkg::TYPE_PINK:  v34 = acc[63:30];
      mtng_pkg::TYPE_BROWN: v34 = 34'(brown_level);
      default:              v34 = acc[33:0];
    endcase
    v_rnd = 35'(v34) + 35'sd128;
    v_shr = v_rnd[34:8];
    if (v_shr > 27'sd8388607) begin
      sample_next = 24'sh7FFFFF;
    end else if (v_shr < -27'sd8388608) begin
      sample_next = 24'sh800000;
    end else begin
      sample_next = v_shr[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      result_valid    <= 1'b0;
      noise_type      <= mtng_pkg::TYPE_PINK;
      seed_value      <= mtng_pkg::SEED_RESET;
      lcg_state       <= mtng_pkg::SEED_RESET;
      for (int i = 0; i < mtng_pkg::NUM_POLES; i++) begin
        pole[i] <= '0;
      end
      brown_level     <= '0;
      velvet_position <= mtng_pkg::pos_t'(mtng_pkg::CELL_LENGTH);
      velvet_offset   <= '0;
      velvet_positive <= 1'b0;
      idx             <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          mtng_pkg::REG_NOISE_TYPE: noise_type <= cfg_data[1:0];
          mtng_pkg::REG_SEED_VALUE: seed_value <= cfg_data;
          default: begin
          end
        endcase
      end

      // S_OUT reloads the output register itself when it is taken
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (restart) begin
              lcg_state       <= seed_value;
              for (int i = 0; i < mtng_pkg::NUM_POLES; i++) begin
                pole[i] <= '0;
              end
              brown_level     <= '0;
              velvet_position <= mtng_pkg::pos_t'(mtng_pkg::CELL_LENGTH);
              velvet_offset   <= '0;
              velvet_positive <= 1'b0;
            end
            if (noise_type == mtng_pkg::TYPE_VELVET && !restart &&
                velvet_position < mtng_pkg::pos_t'(mtng_pkg::CELL_LENGTH)) begin
              state <= S_V_EMIT;
            end else begin
              state <= S_LCG_MUL;
            end
          end
        end
        S_LCG_MUL: state <= S_LCG_ADD;
        S_LCG_ADD: begin
          lcg_state <= prod[31:0] + mtng_pkg::LCG_INC;
          idx       <= '0;
          unique case (noise_type)
            mtng_pkg::TYPE_PINK:  state <= S_P_G;
            mtng_pkg::TYPE_WHITE: state <= S_W_MUL;
            mtng_pkg::TYPE_BROWN: state <= S_B_G;
            default:              state <= S_V_MUL;
          endcase
        end
        S_P_G: state <= S_P_WB;
        S_P_WB: begin
          pole[idx] <= mtng_pkg::sat32(sum);
          if (idx == mtng_pkg::LAST_LEAKY_POLE) begin
            state <= S_P_SUM0;
          end else begin
            idx   <= 3'(idx + 3'd1);
            state <= S_P_G;
          end
        end
        S_P_SUM0: begin
          idx   <= '0;
          state <= S_P_SUMP;
        end
        S_P_SUMP: begin
          // pole 6 enters the sum with its old value
          if (idx == mtng_pkg::LAST_POLE) begin
            state <= S_P_SL;
          end else begin
            idx <= 3'(idx + 3'd1);
          end
        end
        S_P_SL:  state <= S_P_SH;
        S_P_SH:  state <= S_P_SHC;
        S_P_SHC: state <= S_P_P6;
        S_P_P6: begin
          pole[mtng_pkg::LAST_POLE] <= mtng_pkg::sat32(sum);
          state <= S_OUT;
        end
        S_B_G: state <= S_B_WB;
        S_B_WB: begin
          brown_level <= mtng_pkg::sat32(sum);
          state       <= S_OUT;
        end
        S_W_MUL: state <= S_W_ACC;
        S_W_ACC: state <= S_OUT;
        S_V_MUL: state <= S_V_DRAW;
        S_V_DRAW: begin
          velvet_offset   <= prod[32 +: mtng_pkg::OFS_W];
          velvet_positive <= lcg_state[0];
          velvet_position <= '0;
          state           <= S_V_EMIT;
        end
        S_V_EMIT: begin
          velvet_position <= velvet_position + mtng_pkg::pos_t'(1);
          state           <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            sample       <= sample_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/multi_type_noise_generator_tb.sv =====
// Self-checking testbench for the multi-type noise generator (pink, white, brown, velvet).
`timescale 1ns / 100ps

module multi_type_noise_generator_tb;

  // Run limits: a request can sit behind a long result hold-off, so the
  // watchdog allows far more than the slowest request takes.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_REQUESTS = 50;
  localparam int RANDOM_PHASES  = 35;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [0:0]         cfg_index = mtng_pkg::REG_NOISE_TYPE;
  logic [31:0]        cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               restart = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [23:0] sample;

  multi_type_noise_generator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .restart      (restart),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Generator model: its own copy of the registers and filter state.
  // Filter state and samples are Q4.28 held in 64-bit signed integers.
  // ---------------------------------------------------------------------
  logic [1:0]  model_type = mtng_pkg::TYPE_PINK;
  logic [31:0] model_seed = 32'd48879;
  logic [31:0] lcg_word   = 32'd48879;
  longint      pole_acc [7];
  longint      brown_acc;
  int          cell_pos;
  int          cell_slot;
  logic        cell_sign;

  // Expected samples, oldest first
  logic signed [23:0] samples_due [$];

  int err_count      = 0;
  int requests_sent  = 0;
  int samples_seen   = 0;
  int cfg_writes     = 0;
  int tx_idle_pct    = 15;
  int rx_idle_pct    = 15;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int material_count [4];

  // Decimal coefficient (scaled by 1e7) to Q2.30, rounded to nearest
  function automatic longint q30_coef(input longint scaled);
    return (scaled * 64'sd1073741824 + 64'sd5000000) / 64'sd10000000;
  endfunction

  // Exact product, then round half up back to Q4.28
  function automatic longint mul_round(input longint x, input longint c);
    return (x * c + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clip_q428(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint leak_coef(input int i);
    case (i)
      0: return q30_coef(9988600);
      1: return q30_coef(9933200);
      2: return q30_coef(9690000);
      3: return q30_coef(8665000);
      4: return q30_coef(5500000);
      default: return -q30_coef(7616000);
    endcase
  endfunction

  function automatic longint drive_coef(input int i);
    case (i)
      0: return q30_coef(555179);
      1: return q30_coef(750759);
      2: return q30_coef(1538520);
      3: return q30_coef(3104856);
      4: return q30_coef(5329522);
      default: return -q30_coef(168980);
    endcase
  endfunction

  function automatic void clear_model_filters();
    for (int i = 0; i < 7; i++) pole_acc[i] = 0;
    brown_acc = 0;
    cell_pos  = mtng_pkg::CELL_LENGTH;   // forces a fresh cell on the next velvet sample
    cell_slot = 0;
    cell_sign = 1'b0;
  endfunction

  // One LCG step; returns the white value in [-1, 1) as Q4.28
  function automatic longint next_white();
    lcg_word = lcg_word * 32'd1664525 + 32'd1013904223;
    return longint'({32'd0, lcg_word >> 3}) - 64'sd268435456;
  endfunction

  function automatic logic signed [23:0] predict_sample(input logic reload);
    longint w;
    longint acc;
    longint v;
    longint amp;
    longint unsigned slot;
    v = 0;
    if (reload) begin
      lcg_word = model_seed;
      clear_model_filters();
    end
    case (model_type)
      mtng_pkg::TYPE_WHITE: begin
        v = mul_round(next_white(), q30_coef(2600000));
      end
      mtng_pkg::TYPE_BROWN: begin
        w = next_white();
        brown_acc = clip_q428(mul_round(brown_acc, q30_coef(9980000)) +
                              mul_round(w, q30_coef(200000)));
        v = brown_acc;
      end
      mtng_pkg::TYPE_VELVET: begin
        if (cell_pos >= mtng_pkg::CELL_LENGTH) begin
          w = next_white();
          slot = ({32'd0, lcg_word} * mtng_pkg::CELL_LENGTH) >> 32;
          cell_slot = int'(slot);
          cell_sign = lcg_word[0];
          cell_pos  = 0;
        end
        if (cell_pos == cell_slot) begin
          amp = (64'sd6 * 64'sd268435456 + 64'sd5) / 64'sd10;
          v = cell_sign ? amp : -amp;
        end
        cell_pos++;
      end
      default: begin
        w = next_white();
        for (int i = 0; i < 6; i++)
          pole_acc[i] = clip_q428(mul_round(pole_acc[i], leak_coef(i)) +
                                  mul_round(w, drive_coef(i)));
        // last pole joins the sum with its previous value
        acc = mul_round(w, q30_coef(5362000));
        for (int i = 0; i < 7; i++) acc += pole_acc[i];
        v = mul_round(acc, q30_coef(1100000));
        pole_acc[6] = clip_q428(mul_round(w, q30_coef(1159260)));
      end
    endcase
    v = (v + 64'sd128) >>> 8;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  // ---------------------------------------------------------------------
  // Result side: checks each accepted sample, then picks the next stall.
  // A hold-off asked for by a test is counted down here from HOLD_CYCLES.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [23:0] want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        samples_seen++;
        if (samples_due.size() == 0) begin
          $error("unexpected sample %0d with nothing outstanding", sample);
          err_count++;
        end else begin
          want = samples_due.pop_front();
          if (sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, sample);
            err_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        hold_left    <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: too long without any request or result accepted
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_type_noise_generator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------

  // Offer one request; returns at the edge where it is accepted, with
  // item_valid still high so back-to-back requests need no re-raise.
  task automatic send_request(input logic reload);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    restart    <= reload;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    samples_due.push_back(predict_sample(reload));
    material_count[model_type]++;
    requests_sent++;
  endtask

  // Drop valid, drain every outstanding sample, then let the block settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while idle
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == mtng_pkg::REG_NOISE_TYPE) model_type = data[1:0];
    else model_seed = data;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Pink at reset defaults: first sample runs from the reset seed, then a
  // restart reloads it and clears the poles.
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();
  endtask

  // White and brown with the seed extremes, then pink; the pink step switches
  // type without restart, so it must run on from the poles that the earlier restarts cleared.
  task automatic test_each_material();
    write_reg(mtng_pkg::REG_SEED_VALUE, 32'h0000_0000);
    write_reg(mtng_pkg::REG_NOISE_TYPE, 32'(mtng_pkg::TYPE_WHITE));
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();
    write_reg(mtng_pkg::REG_SEED_VALUE, 32'hFFFF_FFFF);
    write_reg(mtng_pkg::REG_NOISE_TYPE, 32'(mtng_pkg::TYPE_BROWN));
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();
    write_reg(mtng_pkg::REG_NOISE_TYPE, 32'(mtng_pkg::TYPE_PINK));
    send_request(1'b0);
    wait_idle();
  endtask

  // Velvet across a cell boundary: the first sample draws a cell, the
  // seventeenth draws the next one.
  task automatic test_velvet_cells();
    write_reg(mtng_pkg::REG_NOISE_TYPE, 32'(mtng_pkg::TYPE_VELVET));
    send_request(1'b1);
    for (int i = 0; i < mtng_pkg::CELL_LENGTH + 1; i++) send_request(1'b0);
    wait_idle();
  endtask

  // Phases of random requests under random settings. Restarts are rare so
  // the filters run deep; type switches keep each material's state.
  task automatic test_random_stream();
    logic [31:0] seed;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(9))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hFFFF_FFFF;
        default: seed = $urandom;
      endcase
      write_reg(mtng_pkg::REG_SEED_VALUE, seed);
      write_reg(mtng_pkg::REG_NOISE_TYPE, $urandom_range(3));
      // one phase runs with no idling on either side
      if (p == RANDOM_PHASES / 2) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      for (int i = 0; i < PHASE_REQUESTS; i++)
        send_request($urandom_range(99) < 5);
      wait_idle();
      tx_idle_pct = 15;
      rx_idle_pct <= 15;
    end
  endtask

  // Long result hold-off while requests keep coming, so the output register
  // fills and the block stalls its request side.
  task automatic test_stall_pressure();
    write_reg(mtng_pkg::REG_NOISE_TYPE, 32'(mtng_pkg::TYPE_WHITE));
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) send_request(i == 0);
    wait_idle();
  endtask

  initial begin
    clear_model_filters();
    for (int i = 0; i < 4; i++) material_count[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_each_material();
    test_velvet_cells();
    test_random_stream();
    test_stall_pressure();
    wait_idle();

    if (samples_due.size() != 0) begin
      $error("%0d samples never arrived", samples_due.size());
      err_count++;
    end
    $display("Ran %0d requests (pink %0d, white %0d, brown %0d, velvet %0d), %0d reg writes.",
             requests_sent, material_count[mtng_pkg::TYPE_PINK],
             material_count[mtng_pkg::TYPE_WHITE], material_count[mtng_pkg::TYPE_BROWN],
             material_count[mtng_pkg::TYPE_VELVET], cfg_writes);
    $display("Checked %0d samples under random stalls and one long hold-off; %0d errors.",
             samples_seen, err_count);
    if (err_count == 0) begin
      $display("multi_type_noise_generator regression: pass");
    end else begin
      $display("multi_type_noise_generator regression: fail");
    end
    $finish;
  end

endmodule
